>>> rtl/core/fwl_pkg.sv
package fwl_pkg;

    // Default geometry of the worklist.
    localparam int DEPTH_DEFAULT    = 64;
    localparam int ID_WIDTH_DEFAULT = 16;

    // Widths of the command and result fields on the ports.
    localparam int ENTRY_ID_W  = 16;
    localparam int OCCUPANCY_W = 7;

    typedef enum logic [1:0] {
        OP_SELECT  = 2'd0,
        OP_PUSH    = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_REQUEUE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FRONT,
        S_REPLY
    } state_t;

endpackage

>>> rtl/core/fifo_worklist_with_requeue.sv
// Channel   Direction  Signals                           Transaction completes when
// command   in         start, opcode, entry_id           start high and busy low at clk rise
// result    out        done, front_id, status, occupancy done high (one cycle, no back-pressure)
//
// Select and push go through the front read and the reply state to the result strobe.
// Remove and requeue scan the ring through the single read port of the entry
// memory, one entry per cycle, up to the first match, and then move the later
// entries forward, one per cycle. Scan and shift together cover the held entries once.
// Reset clears the head pointer and the count; the memory needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle, and
// a new command can be accepted in that same cycle.
module fifo_worklist_with_requeue #(
    parameter int DEPTH    = fwl_pkg::DEPTH_DEFAULT,
    parameter int ID_WIDTH = fwl_pkg::ID_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [1:0]                         opcode,
    input  logic [fwl_pkg::ENTRY_ID_W-1:0]     entry_id,
    output logic                               busy,
    output logic                               done,
    output logic [fwl_pkg::ENTRY_ID_W-1:0]     front_id,
    output logic [1:0]                         status,
    output logic [fwl_pkg::OCCUPANCY_W-1:0]    occupancy
);

    // Slot index width and count width (the count must hold DEPTH itself).
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Maps a position counted from the front to a physical slot in the ring.
    // The sum stays below twice the depth, so one subtract wraps it.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                              input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(p);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return AW'(s);
    endfunction

    fwl_pkg::state_t  state_reg, state_next;
    fwl_pkg::op_t     op_reg, op_next;
    fwl_pkg::status_t stat_reg, stat_next;

    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;

    // Scan and shift bookkeeping. ip is the next position to read during the
    // scan; rp and wp are the read and write positions while closing a gap;
    // pend marks a read whose data arrives in the current cycle.
    logic [CW-1:0] ip_reg, ip_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic          pend_reg, pend_next;

    // Result registers.
    logic                            done_reg, done_next;
    logic [fwl_pkg::ENTRY_ID_W-1:0]  front_reg, front_next;
    fwl_pkg::status_t                res_stat_reg, res_stat_next;
    logic [fwl_pkg::OCCUPANCY_W-1:0] occ_reg, occ_next;

    // Entry memory: one write port, one registered read port.
    logic [ID_WIDTH-1:0] mem [DEPTH];
    logic [ID_WIDTH-1:0] rdata_reg;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic [AW-1:0]       raddr;

    logic          match;
    logic [CW-1:0] match_pos;

    assign match     = pend_reg && (rdata_reg == id_reg);
    assign match_pos = ip_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            front_reg    <= '0;
            res_stat_reg <= fwl_pkg::ST_OK;
            occ_reg      <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
            front_reg    <= front_next;
            res_stat_reg <= res_stat_next;
            occ_reg      <= occ_next;
        end
    end

    // Working registers of the current command carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        stat_reg <= stat_next;
        id_reg   <= id_next;
        ip_reg   <= ip_next;
        rp_reg   <= rp_next;
        wp_reg   <= wp_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        stat_next     = stat_reg;
        id_next       = id_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        ip_next       = ip_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        pend_next     = 1'b0;
        done_next     = 1'b0;
        front_next    = front_reg;
        res_stat_next = res_stat_reg;
        occ_next      = occ_reg;
        we            = 1'b0;
        waddr         = slot_of(head_reg, count_reg);
        wdata         = ID_WIDTH'(entry_id);
        raddr         = head_reg;

        unique case (state_reg)
            fwl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next   = fwl_pkg::op_t'(opcode);
                    id_next   = ID_WIDTH'(entry_id);
                    stat_next = fwl_pkg::ST_OK;
                    ip_next   = '0;
                    unique case (fwl_pkg::op_t'(opcode))
                        fwl_pkg::OP_SELECT:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = fwl_pkg::ST_EMPTY;
                            end
                            state_next = fwl_pkg::S_FRONT;
                        end
                        fwl_pkg::OP_PUSH:
                        begin
                            // The push is written at once into the slot
                            // after the last entry.
                            if (count_reg == CW'(DEPTH))
                            begin
                                stat_next = fwl_pkg::ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = fwl_pkg::S_FRONT;
                        end
                        fwl_pkg::OP_REMOVE,
                        fwl_pkg::OP_REQUEUE:
                        begin
                            state_next = fwl_pkg::S_SEARCH;
                        end
                    endcase
                end
            end

            fwl_pkg::S_SEARCH:
            begin
                // A read is issued every cycle; its data is compared in the
                // following cycle, so the scan runs at one entry per cycle.
                raddr = slot_of(head_reg, ip_reg);
                if (match)
                begin
                    if (op_reg == fwl_pkg::OP_REMOVE && match_pos == '0)
                    begin
                        head_next  = slot_of(head_reg, CW'(1));
                        count_next = count_reg - CW'(1);
                        state_next = fwl_pkg::S_FRONT;
                    end
                    else
                    begin
                        rp_next    = match_pos + CW'(1);
                        wp_next    = match_pos;
                        state_next = fwl_pkg::S_SHIFT;
                    end
                end
                else if (ip_reg == count_reg)
                begin
                    if (!pend_reg)
                    begin
                        stat_next  = fwl_pkg::ST_NOT_FOUND;
                        state_next = fwl_pkg::S_FRONT;
                    end
                end
                else
                begin
                    ip_next   = ip_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end

            fwl_pkg::S_SHIFT:
            begin
                // Each entry after the gap is read and written back one
                // place forward in the next cycle. The write position always
                // trails the read position, so the two never collide.
                raddr = slot_of(head_reg, rp_reg);
                if (pend_reg)
                begin
                    we      = 1'b1;
                    waddr   = slot_of(head_reg, wp_reg);
                    wdata   = rdata_reg;
                    wp_next = wp_reg + CW'(1);
                end
                if (rp_reg < count_reg)
                begin
                    rp_next   = rp_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    // Gap closed: a requeue puts the id into the freed last
                    // slot, a remove drops that slot.
                    if (op_reg == fwl_pkg::OP_REQUEUE)
                    begin
                        we    = 1'b1;
                        waddr = slot_of(head_reg, count_reg - CW'(1));
                        wdata = id_reg;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = fwl_pkg::S_FRONT;
                end
            end

            fwl_pkg::S_FRONT:
            begin
                raddr      = head_reg;
                state_next = fwl_pkg::S_REPLY;
            end

            fwl_pkg::S_REPLY:
            begin
                done_next     = 1'b1;
                front_next    = (count_reg == '0) ? '0
                                                  : fwl_pkg::ENTRY_ID_W'(rdata_reg);
                res_stat_next = stat_reg;
                occ_next      = fwl_pkg::OCCUPANCY_W'(count_reg);
                state_next    = fwl_pkg::S_IDLE;
            end

            default:
            begin
                state_next = fwl_pkg::S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != fwl_pkg::S_IDLE);
    assign done      = done_reg;
    assign front_id  = front_reg;
    assign status    = res_stat_reg;
    assign occupancy = occ_reg;

endmodule

>>> rtl/core/fwl_checker.sv
module fwl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic [1:0]                      opcode,
    input logic                            busy,
    input logic                            done,
    input logic [fwl_pkg::ENTRY_ID_W-1:0]  front_id,
    input logic [1:0]                      status,
    input logic [fwl_pkg::OCCUPANCY_W-1:0] occupancy
);

    // Every result belongs to a transaction that was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // One transaction gives one result, never two in a row.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An accepted command makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start work");

    // An empty report means nothing is held and no front id is shown.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fwl_pkg::ST_EMPTY) |-> (occupancy == '0 && front_id == '0))
        else $error("empty status with entries held");

    // Occupancy only changes together with a result.
    a_occ_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(occupancy))
        else $error("occupancy changed without a result");

endmodule

bind fifo_worklist_with_requeue fwl_checker u_fwl_checker (.*);

>>> test/tb_fifo_worklist_with_requeue.sv
`timescale 1ns / 100ps

// One expected result of the worklist, one per command transaction.
typedef struct packed {
    logic [fwl_pkg::ENTRY_ID_W-1:0]  front_id;
    fwl_pkg::status_t                status;
    logic [fwl_pkg::OCCUPANCY_W-1:0] occupancy;
} worklist_result_t;

// The scoreboard keeps its own picture of the worklist as an ordered list of
// ids, front first. The ring, the head pointer and the count inside the
// block are one way of holding the same ordered list.
class worklist_scoreboard;
    localparam int QUEUE_DEPTH = fwl_pkg::DEPTH_DEFAULT;
    localparam int ID_BITS     = fwl_pkg::ID_WIDTH_DEFAULT;

    logic [fwl_pkg::ENTRY_ID_W-1:0] held_ids[$];
    worklist_result_t               expected_results[$];
    int unsigned                    error_count;

    function new();
        error_count = 0;
    endfunction

    // Apply one accepted command to the list and queue the result it causes.
    function void note_command(fwl_pkg::op_t op, logic [fwl_pkg::ENTRY_ID_W-1:0] id);
        worklist_result_t               exp_r;
        logic [fwl_pkg::ENTRY_ID_W-1:0] id_bits;
        int                             pos;
        int                             i;
        id_bits = id & fwl_pkg::ENTRY_ID_W'((64'd1 << ID_BITS) - 64'd1);
        exp_r.status = fwl_pkg::ST_OK;
        // Only the frontmost copy of a duplicated id is ever touched.
        pos = -1;
        for (i = 0; i < held_ids.size(); i++)
        begin
            if (pos < 0 && held_ids[i] == id_bits)
                pos = i;
        end
        case (op)
            fwl_pkg::OP_SELECT:
            begin
                if (held_ids.size() == 0)
                    exp_r.status = fwl_pkg::ST_EMPTY;
            end
            fwl_pkg::OP_PUSH:
            begin
                if (held_ids.size() >= QUEUE_DEPTH)
                    exp_r.status = fwl_pkg::ST_FULL;
                else
                    held_ids = {held_ids, id_bits};
            end
            fwl_pkg::OP_REMOVE:
            begin
                if (pos < 0)
                    exp_r.status = fwl_pkg::ST_NOT_FOUND;
                else
                    held_ids.delete(pos);
            end
            default:
            begin
                if (pos < 0)
                begin
                    exp_r.status = fwl_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    held_ids.delete(pos);
                    held_ids = {held_ids, id_bits};
                end
            end
        endcase
        exp_r.front_id  = (held_ids.size() == 0) ? '0 : held_ids[0];
        exp_r.occupancy = fwl_pkg::OCCUPANCY_W'(held_ids.size());
        expected_results = {expected_results, exp_r};
    endfunction

    // Compare one result strobe with the oldest expected result.
    function void check_result(logic [fwl_pkg::ENTRY_ID_W-1:0] front_id, logic [1:0] status,
                               logic [fwl_pkg::OCCUPANCY_W-1:0] occupancy);
        worklist_result_t exp_r;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result with no command outstanding: front_id %h status %0d occupancy %0d",
                     $time, front_id, status, occupancy);
            error_count++;
        end
        else
        begin
            exp_r = expected_results[0];
            expected_results.delete(0);
            if (front_id !== exp_r.front_id)
            begin
                $display("%0t: front_id mismatch: expected %h actual %h",
                         $time, exp_r.front_id, front_id);
                error_count++;
            end
            if (status !== 2'(exp_r.status))
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_r.status, status);
                error_count++;
            end
            if (occupancy !== exp_r.occupancy)
            begin
                $display("%0t: occupancy mismatch: expected %0d actual %0d",
                         $time, exp_r.occupancy, occupancy);
                error_count++;
            end
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_fifo_worklist_with_requeue;

    // The random part stops once this many command transactions in total
    // have been accepted, the directed ones included.
    localparam int TOTAL_COMMANDS = 1775;

    // Bias of the random traffic: fill the worklist, drain it, or hold it.
    localparam int MODE_FILL     = 0;
    localparam int MODE_DRAIN    = 1;
    localparam int MODE_BALANCED = 2;

    // A remove or requeue walks the held entries about once, so this covers
    // the slowest command with margin.
    localparam int DRAIN_CYCLES = 2 * fwl_pkg::DEPTH_DEFAULT + 20;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic [1:0]                      opcode = fwl_pkg::OP_SELECT;
    logic [fwl_pkg::ENTRY_ID_W-1:0]  entry_id = '0;
    logic                            busy;
    logic                            done;
    logic [fwl_pkg::ENTRY_ID_W-1:0]  front_id;
    logic [1:0]                      status;
    logic [fwl_pkg::OCCUPANCY_W-1:0] occupancy;

    worklist_scoreboard sb = new();

    int unsigned commands_sent = 0;
    int unsigned burst_left = 0;

    fifo_worklist_with_requeue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .entry_id  (entry_id),
        .busy      (busy),
        .done      (done),
        .front_id  (front_id),
        .status    (status),
        .occupancy (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked at the edge
    // that ends its cycle. Sampling at the edge sees the values the block
    // drove during the cycle that just ended.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(front_id, status, occupancy);
    end

    // Ids come from a small pool in four picks of ten, so that duplicates
    // and hits on held ids are common; the rest spans the whole field.
    function automatic logic [fwl_pkg::ENTRY_ID_W-1:0] random_id();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return fwl_pkg::ENTRY_ID_W'($urandom_range(15));
        else if (pick == 4)
            return $urandom_range(1) ? '1 : '0;
        else
            return fwl_pkg::ENTRY_ID_W'($urandom_range(16'hFFFF));
    endfunction

    // A held id (a random one if none is held), so that removes and requeues
    // find their target and shift entries at every position.
    function automatic logic [fwl_pkg::ENTRY_ID_W-1:0] held_id();
        if (sb.held_ids.size() == 0)
            return random_id();
        return sb.held_ids[$urandom_range(sb.held_ids.size() - 1)];
    endfunction

    // The sender idles between bursts. Most gaps are short, a few are long
    // enough to outlast the slowest command, so idle cycles land on every
    // phase of the block's work. Opcode and id carry noise while start is low.
    task automatic idle_gap();
        int unsigned gap;
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick < 14)
            gap = $urandom_range(6, 1);
        else if (pick < 19)
            gap = $urandom_range(40, 7);
        else
            gap = $urandom_range(150, 41);
        start <= 1'b0;
        repeat (gap)
        begin
            opcode   <= 2'($urandom_range(3));
            entry_id <= fwl_pkg::ENTRY_ID_W'($urandom_range(16'hFFFF));
            @(posedge clk);
        end
        // Occasional long bursts give stretches with no idling at all.
        burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 40) : $urandom_range(20);
    endtask

    // Present one command and hold it until the block takes it. Start stays
    // high into the next command when the burst goes on, so it is assigned
    // once per time step.
    task automatic send_command(fwl_pkg::op_t op, logic [fwl_pkg::ENTRY_ID_W-1:0] id);
        start    <= 1'b1;
        opcode   <= op;
        entry_id <= id;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_command(op, id);
        commands_sent++;
        if (burst_left > 0)
            burst_left--;
        else
            idle_gap();
    endtask

    // Directed commands: the empty queue, ids at both extremes, duplicates,
    // removes at the front, in the middle and at the back, requeues of the
    // front and of the back entry, and ids that are not held.
    task automatic run_directed();
        send_command(fwl_pkg::OP_SELECT,  16'h0000);
        send_command(fwl_pkg::OP_REMOVE,  16'h0000);
        send_command(fwl_pkg::OP_REQUEUE, 16'hFFFF);
        send_command(fwl_pkg::OP_PUSH,    16'h0000);
        send_command(fwl_pkg::OP_PUSH,    16'hFFFF);
        send_command(fwl_pkg::OP_PUSH,    16'h1234);
        send_command(fwl_pkg::OP_PUSH,    16'h0000);
        send_command(fwl_pkg::OP_SELECT,  16'hFFFF);
        send_command(fwl_pkg::OP_REQUEUE, 16'h0000);
        send_command(fwl_pkg::OP_REMOVE,  16'hFFFF);
        send_command(fwl_pkg::OP_PUSH,    16'hA5A5);
        send_command(fwl_pkg::OP_REMOVE,  16'h0000);
        send_command(fwl_pkg::OP_REQUEUE, 16'hA5A5);
        send_command(fwl_pkg::OP_REQUEUE, 16'h1234);
        send_command(fwl_pkg::OP_REMOVE,  16'h5555);
        send_command(fwl_pkg::OP_REQUEUE, 16'h5A5A);
        send_command(fwl_pkg::OP_REMOVE,  16'h1234);
        send_command(fwl_pkg::OP_REMOVE,  16'h0000);
        send_command(fwl_pkg::OP_REMOVE,  16'hA5A5);
        send_command(fwl_pkg::OP_SELECT,  16'h0000);
        send_command(fwl_pkg::OP_PUSH,    16'h8000);
        send_command(fwl_pkg::OP_PUSH,    16'h0001);
        send_command(fwl_pkg::OP_REQUEUE, 16'h8000);
        send_command(fwl_pkg::OP_REMOVE,  16'h0001);
    endtask

    // Random traffic is mostly host-style episodes: a requeue of the current
    // entry, then pushes of new ids, then removals of finished ones, and
    // sometimes a select. Fill phases drive the worklist into the full case,
    // drain phases empty it. About one step in five is a random command.
    task automatic run_random();
        int          mode;
        int unsigned episodes;
        int unsigned n_push;
        int unsigned n_remove;
        while (commands_sent < TOTAL_COMMANDS)
        begin
            mode = $urandom_range(MODE_BALANCED);
            episodes = $urandom_range(40, 10);
            while (episodes > 0 && commands_sent < TOTAL_COMMANDS)
            begin
                episodes--;
                case (mode)
                    MODE_FILL:
                    begin
                        n_push   = $urandom_range(4, 1);
                        n_remove = $urandom_range(1);
                    end
                    MODE_DRAIN:
                    begin
                        n_push   = $urandom_range(1);
                        n_remove = $urandom_range(4, 1);
                    end
                    default:
                    begin
                        n_push   = $urandom_range(2);
                        n_remove = $urandom_range(2);
                    end
                endcase
                if ($urandom_range(9) < 2)
                begin
                    send_command(fwl_pkg::op_t'($urandom_range(3)), random_id());
                end
                else
                begin
                    if ($urandom_range(3) != 0)
                    begin
                        if ($urandom_range(1) && sb.held_ids.size() != 0)
                            send_command(fwl_pkg::OP_REQUEUE, sb.held_ids[0]);
                        else
                            send_command(fwl_pkg::OP_REQUEUE, held_id());
                    end
                    repeat (n_push)
                        send_command(fwl_pkg::OP_PUSH, random_id());
                    repeat (n_remove)
                        send_command(fwl_pkg::OP_REMOVE,
                                     ($urandom_range(9) < 8) ? held_id() : random_id());
                    if ($urandom_range(1))
                        send_command(fwl_pkg::OP_SELECT,
                                     fwl_pkg::ENTRY_ID_W'($urandom_range(16'hFFFF)));
                end
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(20);
        run_directed();
        run_random();
        start <= 1'b0;
        // Every command gives exactly one result; wait for the last of them,
        // then watch a while longer for any stray strobe.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
